// ----- rtl/core/ems_pkg.sv -----
package ems_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = 11;
  localparam int MAG_W      = 16;
  localparam int SUM_W      = 26;
  localparam int SQ_W       = 32;
  localparam int BIT_CNT_W  = $clog2(MAG_W);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- rtl/core/ems_sqrt.sv -----
module ems_sqrt
  import ems_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SQ_W-1:0]  operand,
  output unit_stat_t       stat,
  output logic [MAG_W-1:0] root
);

  logic [SQ_W-1:0] rem_r, rem_nxt;
  logic [SQ_W-1:0] root_r, root_nxt;
  logic [SQ_W-1:0] bit_r, bit_nxt;
  logic [SQ_W-1:0] trial;
  logic            busy_r, done_r;

  // one result bit per cycle, bit walks down by two places
  always_comb begin
    trial    = root_r + bit_r;
    rem_nxt  = rem_r;
    root_nxt = root_r >> 1;
    bit_nxt  = bit_r >> 2;
    if (rem_r >= trial) begin
      rem_nxt  = rem_r - trial;
      root_nxt = (root_r >> 1) + bit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= operand;
        root_r <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        bit_r  <= bit_nxt;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r[MAG_W-1:0];

endmodule

// ----- rtl/core/ems_div.sv -----
module ems_div
  import ems_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output unit_stat_t       stat,
  output logic [MAG_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [CNT_W:0]    trial;
  logic              take;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    take  = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        quo_r  <= dividend;
        div_r  <= divisor;
        step_r <= '0;
      end else if (busy_r) begin
        if (take) begin
          rem_r <= CNT_W'(trial - {1'b0, div_r});
        end else begin
          rem_r <= trial[CNT_W-1:0];
        end
        quo_r  <= {quo_r[SUM_W-2:0], take};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r[MAG_W-1:0];

endmodule

// ----- rtl/core/error_magnitude_stats_core.sv -----
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready   | error_x, error_y, sample_valid, last
// out_    | output    | out_valid / out_ready | point_count, mean/median/min/max_mag,
//         |           |                       | overflowed
//
// Work: a word with a residual holds the input while it is squared, takes its 16-step root
// and is stored. A word with neither residual nor last is taken and the block stays idle.
// A word with last then runs the median selection: 16 passes over the n stored
// magnitudes, doubled for an even count; each pass reads them one at a time through
// the single read port of the magnitude memory. The mean divider runs alongside.
// Reset: synchronous, active low; clears counters and handshakes, memory is not cleared.
// Stalls: a waiting result sits in the output register; input is taken meanwhile
// until the next result is ready to be loaded.
module error_magnitude_stats_core
  import ems_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      in_error_x,
  input  logic [15:0]      in_error_y,
  input  logic             in_sample_valid,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CNT_W-1:0] out_point_count,
  output logic [MAG_W-1:0] out_mean_mag,
  output logic [MAG_W-1:0] out_median_mag,
  output logic [MAG_W-1:0] out_min_mag,
  output logic [MAG_W-1:0] out_max_mag,
  output logic             out_overflowed
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SQRT, S_STATS, S_SCAN, S_WAITDIV, S_FIN
  } state_t;

  state_t state_r;

  // captured word
  logic        last_r;

  // squares
  logic [16:0]     ax, ay;
  logic [SQ_W-2:0] sqx_r, sqy_r;
  logic [SQ_W-1:0] sq_sum;

  // set state
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] sum_r;
  logic             drop_r;
  logic [MAG_W-1:0] min_r, max_r;

  // magnitude memory
  logic [MAG_W-1:0] mem [MAX_POINTS];
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [MAG_W-1:0] mem_rdata_r;

  // median selection: bitwise search for the k-th smallest
  logic [CNT_W-1:0]     issue_r;
  logic                 rd_v_r;
  logic [CNT_W-1:0]     lt_cnt_r;
  logic [CNT_W-1:0]     k_r;
  logic [MAG_W-1:0]     pfx_r;
  logic [BIT_CNT_W-1:0] bit_r;
  logic                 second_r;
  logic [MAG_W-1:0]     med_a_r, med_b_r;
  logic [MAG_W-1:0]     cand;
  logic [MAG_W-1:0]     pfx_new;
  logic [MAG_W:0]       med_pair;

  // units
  logic             sq_start, div_start;
  unit_stat_t       sq_stat, div_stat;
  logic [MAG_W-1:0] mag, mean_q;

  // output register
  logic             out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [MAG_W-1:0] out_mean_r, out_med_r, out_min_r, out_max_r;
  logic             out_ovf_r;

  assign in_ready = (state_r == S_IDLE);

  // squares taken straight from the offered word; valid in S_MUL after the accept
  always_comb begin
    ax = in_error_x[15] ? 17'(-$signed({in_error_x[15], in_error_x})) : {1'b0, in_error_x};
    ay = in_error_y[15] ? 17'(-$signed({in_error_y[15], in_error_y})) : {1'b0, in_error_y};
  end

  assign sq_sum    = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign sq_start  = (state_r == S_MUL);
  assign div_start = (state_r == S_STATS) && (cnt_r != '0);

  ems_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_sum),
    .stat    (sq_stat),
    .root    (mag)
  );

  ems_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .stat     (div_stat),
    .quotient (mean_q)
  );

  // store on root completion while there is room
  assign mem_we    = (state_r == S_SQRT) && sq_stat.done && (cnt_r < CNT_W'(MAX_POINTS));
  assign mem_waddr = cnt_r[ADDR_W-1:0];
  assign mem_raddr = issue_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mag;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  assign cand     = pfx_r | (MAG_W'(1) << bit_r);
  assign pfx_new  = (lt_cnt_r <= k_r) ? cand : pfx_r;
  assign med_pair = {1'b0, med_a_r} + {1'b0, med_b_r};

  always_ff @(posedge clk) begin
    sqx_r <= (SQ_W-1)'({17'd0, ax} * {17'd0, ax});
    sqy_r <= (SQ_W-1)'({17'd0, ay} * {17'd0, ay});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      // S_FIN handles the output register itself
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            last_r <= in_last;
            if (in_sample_valid) begin
              state_r <= S_MUL;
            end else if (in_last) begin
              state_r <= S_STATS;
            end
          end
        end
        S_MUL: begin
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_stat.done) begin
            if (mem_we) begin
              cnt_r <= cnt_r + 1'b1;
              sum_r <= sum_r + SUM_W'(mag);
              if (cnt_r == '0 || mag < min_r) min_r <= mag;
              if (cnt_r == '0 || mag > max_r) max_r <= mag;
            end else begin
              drop_r <= 1'b1;
            end
            state_r <= last_r ? S_STATS : S_IDLE;
          end
        end
        S_STATS: begin
          if (cnt_r == '0) begin
            med_a_r <= '0;
            med_b_r <= '0;
            state_r <= S_FIN;
          end else begin
            k_r      <= (cnt_r - 1'b1) >> 1;
            pfx_r    <= '0;
            bit_r    <= BIT_CNT_W'(MAG_W - 1);
            second_r <= 1'b0;
            issue_r  <= '0;
            lt_cnt_r <= '0;
            rd_v_r   <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_v_r <= (issue_r < cnt_r);
          if (issue_r < cnt_r) begin
            issue_r <= issue_r + 1'b1;
          end
          if (rd_v_r && mem_rdata_r < cand) begin
            lt_cnt_r <= lt_cnt_r + 1'b1;
          end
          if (issue_r == cnt_r && !rd_v_r) begin
            // end of one pass over the set
            issue_r  <= '0;
            lt_cnt_r <= '0;
            if (bit_r != '0) begin
              pfx_r <= pfx_new;
              bit_r <= bit_r - 1'b1;
            end else if (!second_r) begin
              med_a_r <= pfx_new;
              med_b_r <= pfx_new;
              if (!cnt_r[0]) begin
                second_r <= 1'b1;
                k_r      <= k_r + 1'b1;
                pfx_r    <= '0;
                bit_r    <= BIT_CNT_W'(MAG_W - 1);
              end else begin
                state_r <= S_WAITDIV;
              end
            end else begin
              med_b_r <= pfx_new;
              state_r <= S_WAITDIV;
            end
          end
        end
        S_WAITDIV: begin
          if (!div_stat.busy) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_cnt_r   <= cnt_r;
            out_mean_r  <= (cnt_r == '0) ? '0 : mean_q;
            out_med_r   <= med_pair[MAG_W:1];
            out_min_r   <= (cnt_r == '0) ? '0 : min_r;
            out_max_r   <= (cnt_r == '0) ? '0 : max_r;
            out_ovf_r   <= drop_r;
            cnt_r       <= '0;
            sum_r       <= '0;
            drop_r      <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_count = out_cnt_r;
  assign out_mean_mag    = out_mean_r;
  assign out_median_mag  = out_med_r;
  assign out_min_mag     = out_min_r;
  assign out_max_mag     = out_max_r;
  assign out_overflowed  = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("stored count beyond capacity");

  a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> state_r == S_SQRT)
    else $error("root finished outside its wait state");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cnt_r == '0 |-> out_min_r == '0 && out_max_r == '0
      && out_mean_r == '0 && out_med_r == '0)
    else $error("empty set gave non-zero statistics");

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !mem_we)
    else $error("memory write during selection scan");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import ems_pkg::*;

  // One closed set's statistics, as carried by the result channel.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [MAG_W-1:0] mean;
    logic [MAG_W-1:0] median;
    logic [MAG_W-1:0] min_v;
    logic [MAG_W-1:0] max_v;
    logic             ovf;
  } mag_stats_t;

  // Longest run without any handshake. The worst case is the median pass over
  // a full store: 16 passes over its 1024 magnitudes, doubled for an even count.
  // A long receiver hold-off can add to that.
  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 3000;

  // Residual set predictor and the queue of statistics still owed by the block.
  class mag_stats_board;
    logic [MAG_W-1:0] mags[$];
    logic [SUM_W-1:0] mag_sum;
    bit               dropped;
    mag_stats_t       owed[$];
    int               errors;

    function new();
      mag_sum = '0;
      dropped = 0;
      errors  = 0;
    endfunction

    function automatic logic [MAG_W-1:0] root_of(logic [SQ_W-1:0] n);
      logic [SQ_W-1:0] root;
      logic [SQ_W-1:0] bitv;
      root = '0;
      bitv = 32'h4000_0000;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n    = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root[MAG_W-1:0];
    endfunction

    function automatic logic [16:0] abs_of(logic [15:0] v);
      return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    endfunction

    function void note_input(logic [15:0] ex, logic [15:0] ey, logic sv, logic lst);
      logic [16:0]      ax;
      logic [16:0]      ay;
      logic [MAG_W-1:0] m;
      logic [MAG_W-1:0] sorted[$];
      mag_stats_t       s;
      int               n;
      if (sv) begin
        ax = abs_of(ex);
        ay = abs_of(ey);
        m  = root_of(SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay));
        if (mags.size() < MAX_POINTS) begin
          mags.insert(mags.size(), m);
          mag_sum = mag_sum + SUM_W'(m);
        end else begin
          dropped = 1;
        end
      end
      if (!lst) return;
      s = '0;
      n = mags.size();
      if (n > 0) begin
        sorted = mags;
        sorted.sort();
        s.mean  = MAG_W'(mag_sum / n);
        s.min_v = sorted[0];
        s.max_v = sorted[n-1];
        if (n % 2) s.median = sorted[n/2];
        else s.median = MAG_W'(({1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]}) >> 1);
      end
      s.count = CNT_W'(n);
      s.ovf   = dropped;
      owed.insert(owed.size(), s);
      mags.delete();
      mag_sum = '0;
      dropped = 0;
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(mag_stats_t got);
      mag_stats_t want;
      if (owed.size() == 0) begin
        report_mismatch("unexpected result, count", got.count, -1);
        return;
      end
      want = owed.pop_front();
      if (got.count  !== want.count)  report_mismatch("point_count", got.count, want.count);
      if (got.mean   !== want.mean)   report_mismatch("mean_mag", got.mean, want.mean);
      if (got.median !== want.median) report_mismatch("median_mag", got.median, want.median);
      if (got.min_v  !== want.min_v)  report_mismatch("min_mag", got.min_v, want.min_v);
      if (got.max_v  !== want.max_v)  report_mismatch("max_mag", got.max_v, want.max_v);
      if (got.ovf    !== want.ovf)    report_mismatch("overflowed", got.ovf, want.ovf);
    endtask

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [15:0]      in_error_x;
  logic [15:0]      in_error_y;
  logic             in_sample_valid;
  logic             in_last;
  logic             out_valid;
  logic             out_ready;
  logic [CNT_W-1:0] out_point_count;
  logic [MAG_W-1:0] out_mean_mag;
  logic [MAG_W-1:0] out_median_mag;
  logic [MAG_W-1:0] out_min_mag;
  logic [MAG_W-1:0] out_max_mag;
  logic             out_overflowed;

  mag_stats_board board = new();
  int  idle_cycles = 0;
  int  burst_left  = 0;
  bit  hold_req    = 0;   // asks the receiver for one long hold-off

  error_magnitude_stats_core u_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Monitors: both sides sampled at the edge, payload before any update.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_input(in_error_x, in_error_y, in_sample_valid, in_last);
    if (rst_n && out_valid && out_ready)
      board.check_result({out_point_count, out_mean_mag, out_median_mag,
                          out_min_mag, out_max_mag, out_overflowed});
  end

  // Watchdog on handshake silence.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: stall pattern changes every so often; one long hold-off on request.
  initial begin
    int mode;
    int span;
    out_ready = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 300);
        repeat (span) begin
          case (mode)
            0: out_ready <= 1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
          if (hold_req) break;
        end
      end
    end
  end

  // Offer one word and hold it until taken. Bursts end in a random gap, with
  // valid low, so that gaps land on any phase of the block's work.
  task send_word(logic [15:0] ex, logic [15:0] ey, logic sv, logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid        <= 1;
    in_error_x      <= ex;
    in_error_y      <= ey;
    in_sample_valid <= sv;
    in_last         <= lst;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // A set of n residuals; when noisy is set, noise words with sample_valid low are mixed in.
  task send_set(int n, bit noisy);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_word(16'($urandom), 16'($urandom), 0, 0);
      if (i == n - 1 && $urandom_range(0, 1)) send_word(rand_comp(), rand_comp(), 1, 1);
      else send_word(rand_comp(), rand_comp(), 1, 0);
    end
    if (n == 0 || !in_last) send_word(16'($urandom), 16'($urandom), 0, 1);
  endtask

  // One edge first, so the monitor has noted the word just taken.
  task wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int words;
    rst_n           = 0;
    in_valid        = 0;
    in_error_x      = '0;
    in_error_y      = '0;
    in_sample_valid = 0;
    in_last         = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty set, idle word then empty, extremes, valid with last.
    send_word(16'h0000, 16'h0000, 0, 1);
    send_word(16'hffff, 16'hffff, 0, 0);
    send_word(16'h1234, 16'h4321, 0, 1);
    send_word(16'h8000, 16'h8000, 1, 1);
    send_word(16'h7fff, 16'h7fff, 1, 0);
    send_word(16'h0000, 16'h0000, 1, 0);
    send_word(16'hffff, 16'h0000, 1, 0);
    send_word(16'h0000, 16'h8000, 1, 0);
    send_word(16'h5555, 16'haaaa, 0, 0);
    send_word(16'h7fff, 16'h8000, 1, 1);
    send_word(16'h0300, 16'h0400, 1, 0);
    send_word(16'hfd00, 16'hfc00, 1, 0);
    send_word(16'h0000, 16'h0000, 0, 1);
    send_word(16'h0001, 16'h0001, 1, 1);
    wait_drained();

    // Full store, then a residual with last that no longer fits: dropped, flagged.
    for (int i = 0; i < MAX_POINTS; i++)
      send_word(rand_comp(), rand_comp(), 1, 0);
    send_word(16'h8000, 16'h7fff, 1, 1);
    wait_drained();

    // Receiver holds off while small sets keep coming, so the block backs up.
    hold_req = 1;
    for (int i = 0; i < 8; i++) send_set($urandom_range(0, 3), 0);
    wait_drained();

    words = 0;
    while (words < 300) begin
      int n;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      send_set(n, 1);
      words += n + 1;
      if ($urandom_range(0, 29) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ems_pkg.sv
rtl/core/ems_sqrt.sv
rtl/core/ems_div.sv
rtl/core/error_magnitude_stats_core.sv
tb/sv/tb_top.sv
